// ----- design/trpr_pkg.sv -----
// Shared types, character codes and arithmetic helpers of the telemetry record parser.
package trpr_pkg;

  localparam int ACC_W = 64;
  localparam int CNT_W = 4;
  localparam logic [ACC_W-1:0] ACC_CAP = 64'h8000_0000_0000_0000;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_F   = 8'h46;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_G      = 8'h67;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_LC_X   = 8'h78;
  localparam logic [7:0] CH_UC_X   = 8'h58;

  typedef enum logic [7:0] {
    M_WAIT  = 8'b0000_0001,
    M_FIELD = 8'b0000_0010,
    M_COLON = 8'b0000_0100,
    M_LEAD  = 8'b0000_1000,
    M_INT   = 8'b0001_0000,
    M_ZERO  = 8'b0010_0000,
    M_FRAC  = 8'b0100_0000,
    M_SKIP  = 8'b1000_0000
  } mode_t;

  typedef enum logic [2:0] {
    F_TIME  = 3'd0,
    F_CUR   = 3'd1,
    F_VOLT  = 3'd2,
    F_LAT   = 3'd3,
    F_LON   = 3'd4,
    F_SPEED = 3'd5
  } field_t;

  typedef enum logic [1:0] {
    R_DEC = 2'd0,
    R_OCT = 2'd1,
    R_HEX = 2'd2
  } radix_t;

  typedef struct packed {
    logic             valid;
    logic             emit;
    field_t           field;
    logic             neg;
    logic [CNT_W-1:0] k;
    logic [ACC_W-1:0] mag;
  } event_t;

  function automatic logic [ACC_W-1:0] mac_sat(input logic [ACC_W-1:0] acc,
                                               input radix_t r, input logic [3:0] d);
    logic [ACC_W+3:0] p;
    case (r)
      R_HEX:   p = {acc, 4'b0000};
      R_OCT:   p = {1'b0, acc, 3'b000};
      default: p = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
    endcase
    p = p + {{ACC_W{1'b0}}, d};
    return (p > {4'b0000, ACC_CAP}) ? ACC_CAP : p[ACC_W-1:0];
  endfunction

  function automatic logic [ACC_W-1:0] pow10(input int n);
    logic [ACC_W-1:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) p = p * 64'd10;
    return p;
  endfunction

endpackage

// ----- design/trpr_if.sv -----
// Valid/ready channel interfaces for received bytes and parsed records.
interface trpr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface trpr_out_if #(parameter int VALUE_WIDTH = 48);
  logic                           valid;
  logic                           ready;
  logic signed [63:0]             out_time_ms;
  logic signed [VALUE_WIDTH-1:0]  out_current;
  logic signed [VALUE_WIDTH-1:0]  out_voltage;
  logic signed [VALUE_WIDTH-1:0]  out_latitude;
  logic signed [VALUE_WIDTH-1:0]  out_longitude;
  logic signed [VALUE_WIDTH-1:0]  out_speed;
  modport source (output valid, output out_time_ms, output out_current, output out_voltage,
                  output out_latitude, output out_longitude, output out_speed, input ready);
  modport sink (input valid, input out_time_ms, input out_current, input out_voltage,
                input out_latitude, input out_longitude, input out_speed, output ready);
endinterface

// ----- design/trpr_parser.sv -----
// Byte-level parse state machine; emits commit and record-close events.
module trpr_parser #(
  parameter int FRAC_DIGITS = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                en,
  input  logic [7:0]          rx_byte,
  output trpr_pkg::event_t    ev
);

  trpr_pkg::mode_t              mode, mode_next;
  trpr_pkg::field_t             field, field_next;
  trpr_pkg::radix_t             radix, radix_next, radix_e;
  logic [trpr_pkg::ACC_W-1:0]   acc, acc_next;
  logic [trpr_pkg::CNT_W-1:0]   k, k_next;
  logic                         neg, neg_next;
  logic                         seen, seen_next;
  trpr_pkg::event_t             ev_next, ev_take;
  logic                         do_int, do_fin;
  logic [3:0]                   d_val;
  logic                         d_any, d_ok, is_dec, is_ws;

  always_comb begin
    d_val = 4'd0;
    d_any = 1'b0;
    is_dec = rx_byte inside {[trpr_pkg::CH_ZERO:trpr_pkg::CH_NINE]};
    if (is_dec) begin
      d_val = 4'(rx_byte - trpr_pkg::CH_ZERO);
      d_any = 1'b1;
    end else if (rx_byte inside {[trpr_pkg::CH_LC_A:trpr_pkg::CH_LC_F]}) begin
      d_val = 4'(rx_byte - trpr_pkg::CH_LC_A + 8'd10);
      d_any = 1'b1;
    end else if (rx_byte inside {[trpr_pkg::CH_UC_A:trpr_pkg::CH_UC_F]}) begin
      d_val = 4'(rx_byte - trpr_pkg::CH_UC_A + 8'd10);
      d_any = 1'b1;
    end
    is_ws = (rx_byte == trpr_pkg::CH_SPACE) ||
            (rx_byte inside {[trpr_pkg::CH_TAB:trpr_pkg::CH_CR]});
  end

  always_comb begin
    radix_e = (mode == trpr_pkg::M_ZERO) ? trpr_pkg::R_OCT : radix;
    case (radix_e)
      trpr_pkg::R_HEX: d_ok = d_any;
      trpr_pkg::R_OCT: d_ok = d_any && (d_val < 4'd8);
      default:         d_ok = d_any && (d_val < 4'd10);
    endcase
  end

  always_comb begin
    mode_next  = mode;
    field_next = field;
    radix_next = radix;
    acc_next   = acc;
    k_next     = k;
    neg_next   = neg;
    seen_next  = seen;
    do_int     = 1'b0;
    do_fin     = 1'b0;
    ev_next    = '0;
    ev_next.field = field;
    ev_next.neg   = neg;
    ev_next.k     = k;
    ev_next.mag   = acc;
    case (mode)
      trpr_pkg::M_WAIT: begin
        if (rx_byte == trpr_pkg::CH_LBRACE) mode_next = trpr_pkg::M_FIELD;
      end
      trpr_pkg::M_FIELD: begin
        case (rx_byte)
          trpr_pkg::CH_T: begin
            field_next = trpr_pkg::F_TIME;
            mode_next  = trpr_pkg::M_COLON;
          end
          trpr_pkg::CH_LC_A: begin
            field_next = trpr_pkg::F_CUR;
            mode_next  = trpr_pkg::M_COLON;
          end
          trpr_pkg::CH_V: begin
            field_next = trpr_pkg::F_VOLT;
            mode_next  = trpr_pkg::M_COLON;
          end
          trpr_pkg::CH_G: begin
            field_next = trpr_pkg::F_LAT;
            mode_next  = trpr_pkg::M_COLON;
          end
          trpr_pkg::CH_S: begin
            field_next = trpr_pkg::F_SPEED;
            mode_next  = trpr_pkg::M_COLON;
          end
          trpr_pkg::CH_RBRACE: begin
            ev_next.valid = 1'b1;
            ev_next.emit  = 1'b1;
            mode_next     = trpr_pkg::M_WAIT;
          end
          trpr_pkg::CH_SEMI: ;
          default: mode_next = trpr_pkg::M_SKIP;
        endcase
      end
      trpr_pkg::M_COLON: begin
        if (rx_byte == trpr_pkg::CH_COLON) begin
          acc_next   = '0;
          k_next     = '0;
          neg_next   = 1'b0;
          radix_next = trpr_pkg::R_DEC;
          seen_next  = 1'b0;
          mode_next  = trpr_pkg::M_LEAD;
        end else if (rx_byte == trpr_pkg::CH_SEMI) begin
          mode_next = trpr_pkg::M_FIELD;
        end else begin
          mode_next = trpr_pkg::M_SKIP;
        end
      end
      trpr_pkg::M_LEAD: begin
        if (!is_ws) begin
          mode_next = trpr_pkg::M_INT;
          if (rx_byte == trpr_pkg::CH_PLUS || rx_byte == trpr_pkg::CH_MINUS) begin
            neg_next = (rx_byte == trpr_pkg::CH_MINUS);
          end else begin
            do_int = 1'b1;
          end
        end
      end
      trpr_pkg::M_INT: do_int = 1'b1;
      trpr_pkg::M_ZERO: begin
        mode_next = trpr_pkg::M_INT;
        if (rx_byte == trpr_pkg::CH_LC_X || rx_byte == trpr_pkg::CH_UC_X) begin
          radix_next = trpr_pkg::R_HEX;
        end else begin
          radix_next = trpr_pkg::R_OCT;
          do_int     = 1'b1;
        end
      end
      trpr_pkg::M_FRAC: begin
        if (is_dec) begin
          seen_next = 1'b1;
          if (k < trpr_pkg::CNT_W'(FRAC_DIGITS)) begin
            acc_next = trpr_pkg::mac_sat(acc, trpr_pkg::R_DEC, d_val);
            k_next   = k + 1'b1;
          end
        end else begin
          do_fin = 1'b1;
        end
      end
      trpr_pkg::M_SKIP: begin
        if (rx_byte == trpr_pkg::CH_SEMI) mode_next = trpr_pkg::M_FIELD;
      end
      default: mode_next = trpr_pkg::M_WAIT;
    endcase

    if (do_int) begin
      if (field == trpr_pkg::F_TIME && radix_e == trpr_pkg::R_DEC && !seen &&
          rx_byte == trpr_pkg::CH_ZERO) begin
        seen_next = 1'b1;
        mode_next = trpr_pkg::M_ZERO;
      end else if (d_ok) begin
        acc_next  = trpr_pkg::mac_sat(acc, radix_e, d_val);
        seen_next = 1'b1;
      end else if (rx_byte == trpr_pkg::CH_DOT && field != trpr_pkg::F_TIME) begin
        mode_next = trpr_pkg::M_FRAC;
      end else begin
        do_fin = 1'b1;
      end
    end

    if (do_fin) begin
      ev_next.valid = seen;
      if (rx_byte == trpr_pkg::CH_SEMI) begin
        mode_next = trpr_pkg::M_FIELD;
      end else if (field == trpr_pkg::F_LAT && seen && rx_byte == trpr_pkg::CH_COMMA) begin
        field_next = trpr_pkg::F_LON;
        acc_next   = '0;
        k_next     = '0;
        neg_next   = 1'b0;
        radix_next = trpr_pkg::R_DEC;
        seen_next  = 1'b0;
        mode_next  = trpr_pkg::M_LEAD;
      end else begin
        mode_next = trpr_pkg::M_SKIP;
      end
    end
  end

  always_comb begin
    ev_take       = ev_next;
    ev_take.valid = accept && ev_next.valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= trpr_pkg::M_WAIT;
      field <= trpr_pkg::F_TIME;
      radix <= trpr_pkg::R_DEC;
      acc   <= '0;
      k     <= '0;
      neg   <= 1'b0;
      seen  <= 1'b0;
    end else if (accept) begin
      mode  <= mode_next;
      field <= field_next;
      radix <= radix_next;
      acc   <= acc_next;
      k     <= k_next;
      neg   <= neg_next;
      seen  <= seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev.valid <= 1'b0;
    end else if (en) begin
      ev <= ev_take;
    end
  end

endmodule

// ----- design/trpr_scale.sv -----
// One decimal scaling stage: multiplies a pending fixed-point value by ten.
module trpr_scale #(
  parameter int FRAC_DIGITS = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  trpr_pkg::event_t  ev_in,
  output trpr_pkg::event_t  ev_out
);

  trpr_pkg::event_t ev_next;

  always_comb begin
    ev_next = ev_in;
    if (!ev_in.emit && ev_in.field != trpr_pkg::F_TIME &&
        ev_in.k < trpr_pkg::CNT_W'(FRAC_DIGITS)) begin
      ev_next.mag = trpr_pkg::mac_sat(ev_in.mag, trpr_pkg::R_DEC, 4'd0);
      ev_next.k   = ev_in.k + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_out.valid <= 1'b0;
    end else if (en) begin
      ev_out <= ev_next;
    end
  end

endmodule

// ----- design/trpr_record.sv -----
// Record fields, saturation on commit, and a two-beat output buffer.
module trpr_record #(
  parameter int FRAC_DIGITS = 6,
  parameter int VALUE_WIDTH = 48
) (
  input  logic              clk,
  input  logic              rst,
  input  trpr_pkg::event_t  ev,
  output logic              en,
  trpr_out_if.source        out_ch
);

  localparam int REC_W = 64 + 5 * VALUE_WIDTH;
  localparam logic [63:0] ONE_FX    = trpr_pkg::pow10(FRAC_DIGITS);
  localparam logic [63:0] NEG_ONE64 = 64'd0 - ONE_FX;
  localparam logic [VALUE_WIDTH-1:0] NEG_ONE = NEG_ONE64[VALUE_WIDTH-1:0];
  localparam logic [63:0] NEG_MAG   = 64'd1 << (VALUE_WIDTH - 1);
  localparam logic [63:0] POS_MAX   = NEG_MAG - 64'd1;
  localparam logic [63:0] TIME_MAX  = trpr_pkg::ACC_CAP - 64'd1;

  logic [63:0]            rec_time;
  logic [VALUE_WIDTH-1:0] rec_current, rec_voltage, rec_latitude, rec_longitude, rec_speed;
  logic [63:0]            time_v, val_v;
  logic [REC_W-1:0]       slot0, slot1, din;
  logic [1:0]             count;
  logic                   push, pop, go;

  assign en   = (count != 2'd2);
  assign go   = en && ev.valid;
  assign push = go && ev.emit;
  assign pop  = (count != 2'd0) && out_ch.ready;
  assign din  = {rec_time, rec_current, rec_voltage, rec_latitude, rec_longitude, rec_speed};

  always_comb begin
    if (ev.neg) begin
      time_v = 64'd0 - ev.mag;
      val_v  = 64'd0 - ((ev.mag > NEG_MAG) ? NEG_MAG : ev.mag);
    end else begin
      time_v = (ev.mag > TIME_MAX) ? TIME_MAX : ev.mag;
      val_v  = (ev.mag > POS_MAX) ? POS_MAX : ev.mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_time      <= '0;
      rec_current   <= NEG_ONE;
      rec_voltage   <= NEG_ONE;
      rec_latitude  <= '0;
      rec_longitude <= '0;
      rec_speed     <= NEG_ONE;
    end else if (go) begin
      if (ev.emit) begin
        rec_time      <= '0;
        rec_current   <= NEG_ONE;
        rec_voltage   <= NEG_ONE;
        rec_latitude  <= '0;
        rec_longitude <= '0;
        rec_speed     <= NEG_ONE;
      end else begin
        case (ev.field)
          trpr_pkg::F_TIME:  rec_time      <= time_v;
          trpr_pkg::F_CUR:   rec_current   <= val_v[VALUE_WIDTH-1:0];
          trpr_pkg::F_VOLT:  rec_voltage   <= val_v[VALUE_WIDTH-1:0];
          trpr_pkg::F_LAT:   rec_latitude  <= val_v[VALUE_WIDTH-1:0];
          trpr_pkg::F_LON:   rec_longitude <= val_v[VALUE_WIDTH-1:0];
          default:           rec_speed     <= val_v[VALUE_WIDTH-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) slot0 <= slot1;
    if (push) begin
      if (count == 2'd0 || (count == 2'd1 && pop)) begin
        slot0 <= din;
      end else begin
        slot1 <= din;
      end
    end
  end

  assign out_ch.valid         = (count != 2'd0);
  assign out_ch.out_time_ms   = slot0[REC_W-1 -: 64];
  assign out_ch.out_current   = slot0[5*VALUE_WIDTH-1 -: VALUE_WIDTH];
  assign out_ch.out_voltage   = slot0[4*VALUE_WIDTH-1 -: VALUE_WIDTH];
  assign out_ch.out_latitude  = slot0[3*VALUE_WIDTH-1 -: VALUE_WIDTH];
  assign out_ch.out_longitude = slot0[2*VALUE_WIDTH-1 -: VALUE_WIDTH];
  assign out_ch.out_speed     = slot0[VALUE_WIDTH-1:0];

endmodule

// ----- design/telemetry_record_parser_top.sv -----
// Top level of the telemetry record parser.
//
//  channel  dir  beat                    payload
//  in_ch    in   one received character  rx_byte[7:0]
//  out_ch   out  one finished record     out_time_ms[63:0], five VALUE_WIDTH fields
//
// One byte is taken every cycle while the two-beat output buffer has room.
// out_ch.valid rises after the closing-brace event passes the parser register, the
// scaling stages (one decimal scaling stage per fraction digit) and the buffer count.
// Synchronous reset clears the parse state, the pipeline and the buffer, and
// loads the field defaults. When both output beats wait, in_ch.ready drops.
module telemetry_record_parser_top #(
  parameter int FRAC_DIGITS = 6,
  parameter int VALUE_WIDTH = 48
) (
  input  logic        clk,
  input  logic        rst,
  trpr_in_if.sink     in_ch,
  trpr_out_if.source  out_ch
);

  trpr_pkg::event_t ev_s [0:FRAC_DIGITS];
  logic             en;
  logic             accept;

  assign in_ch.ready = en;
  assign accept      = in_ch.valid && en;

  trpr_parser #(.FRAC_DIGITS(FRAC_DIGITS)) u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .en      (en),
    .rx_byte (in_ch.rx_byte),
    .ev      (ev_s[0])
  );

  for (genvar i = 0; i < FRAC_DIGITS; i++) begin : g_scale
    trpr_scale #(.FRAC_DIGITS(FRAC_DIGITS)) u_scale (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .ev_in  (ev_s[i]),
      .ev_out (ev_s[i+1])
    );
  end

  trpr_record #(.FRAC_DIGITS(FRAC_DIGITS), .VALUE_WIDTH(VALUE_WIDTH)) u_record (
    .clk    (clk),
    .rst    (rst),
    .ev     (ev_s[FRAC_DIGITS]),
    .en     (en),
    .out_ch (out_ch)
  );

endmodule

// ----- design/trpr_checker.sv -----
// Port-level checks of the telemetry record parser and their bind.
module trpr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_time_ms
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_time_ms))
    else $error("record beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("buffer not empty after reset");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no record waiting");

  a_stall_pop: assert property (@(posedge clk) disable iff (rst)
    !in_ready && out_ready |=> in_ready)
    else $error("input stayed stalled after a record was taken");

endmodule

bind telemetry_record_parser_top trpr_checker u_trpr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_time_ms (out_ch.out_time_ms)
);
